// ===== src/pidad_pkg.sv =====
// Package: widths, register map, configuration and command types for the PID duty controller
`timescale 1ns / 1ps
`default_nettype none
package pidad_pkg;

   localparam int GAIN_FRAC_BITS   = 8;
   localparam int PERIOD_FRAC_BITS = 16;

   localparam int DATA_W     = 16;
   localparam int ERR_W      = DATA_W + 1;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int GAIN_W     = 16;
   localparam int DUTY_W     = 7;
   localparam int LIMIT_W    = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int INTEG_W  = LIMIT_W + PERIOD_FRAC_BITS + 1;
   localparam int MUL_A_W  = (INTEG_W > DIFF_W) ? INTEG_W : DIFF_W;
   localparam int MUL_B_W  = GAIN_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int IACC_W   = ((INTEG_W > PROD_W) ? INTEG_W : PROD_W) + 1;
   localparam int SCALE_SH = GAIN_FRAC_BITS + PERIOD_FRAC_BITS;
   localparam int ACC_W    = PROD_W + PERIOD_FRAC_BITS + 2;
   localparam int WHOLE_W  = ACC_W - SCALE_SH;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_INTEGRAL_GAIN  = 3'd1,
      CSR_DERIV_GAIN     = 3'd2,
      CSR_PERIOD_FRAC    = 3'd3,
      CSR_BASELINE_DUTY  = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5,
      CSR_DUTY_MIN       = 3'd6,
      CSR_DUTY_MAX       = 3'd7
   } csr_idx_type;

   localparam logic [GAIN_W-1:0]  RST_PROP_GAIN      = 16'd307;
   localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN  = 16'd51;
   localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN     = 16'd10240;
   localparam logic [GAIN_W-1:0]  RST_PERIOD_FRAC    = 16'd655;
   localparam logic [DUTY_W-1:0]  RST_BASELINE_DUTY  = 7'd10;
   localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT = 15'd100;
   localparam logic [DUTY_W-1:0]  RST_DUTY_MIN       = 7'd2;
   localparam logic [DUTY_W-1:0]  RST_DUTY_MAX       = 7'd98;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integral_gain;
      logic [GAIN_W-1:0]  deriv_gain_per_period;
      logic [GAIN_W-1:0]  period_fraction;
      logic [DUTY_W-1:0]  baseline_duty;
      logic [LIMIT_W-1:0] integral_limit;
      logic [DUTY_W-1:0]  duty_min;
      logic [DUTY_W-1:0]  duty_max;
   } cfg_type;

   typedef enum logic [1:0] {
      MUL_ERR_PERIOD  = 2'd0,
      MUL_ERR_PROP    = 2'd1,
      MUL_DIFF_DERIV  = 2'd2,
      MUL_INTEG_IGAIN = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        integ_upd;
      logic        acc_init;
      logic        acc_add_shift;
      logic        acc_add_plain;
      logic        out_load;
   } dp_cmd_type;

endpackage
`default_nettype wire

// ===== src/pidad_if.sv =====
// Interfaces: request, response and register write channels
`timescale 1ns / 1ps
`default_nettype none
interface pidad_req_if;
   import pidad_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] setpoint;
   logic signed [DATA_W-1:0] measured_altitude;
   modport source (output valid, output setpoint, output measured_altitude, input ready);
   modport sink (input valid, input setpoint, input measured_altitude, output ready);
endinterface

interface pidad_rsp_if;
   import pidad_pkg::*;
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty;
   logic              integral_clamped;
   logic              output_clamped;
   modport source (output valid, output duty, output integral_clamped, output output_clamped,
                   input ready);
   modport sink (input valid, input duty, input integral_clamped, input output_clamped,
                 output ready);
endinterface

interface pidad_csr_if;
   import pidad_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/pidad_csr.sv =====
// Configuration register file
`timescale 1ns / 1ps
`default_nettype none
module pidad_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_valid,
   output      logic                            wr_ready,
   input  wire logic [pidad_pkg::CSR_IDX_W-1:0]  wr_index,
   input  wire logic [pidad_pkg::CSR_DATA_W-1:0] wr_data,
   output      pidad_pkg::cfg_type              cfg
);
   import pidad_pkg::*;

   cfg_type cfg_ff;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain             <= RST_PROP_GAIN;
         cfg_ff.integral_gain         <= RST_INTEGRAL_GAIN;
         cfg_ff.deriv_gain_per_period <= RST_DERIV_GAIN;
         cfg_ff.period_fraction       <= RST_PERIOD_FRAC;
         cfg_ff.baseline_duty         <= RST_BASELINE_DUTY;
         cfg_ff.integral_limit        <= RST_INTEGRAL_LIMIT;
         cfg_ff.duty_min              <= RST_DUTY_MIN;
         cfg_ff.duty_max              <= RST_DUTY_MAX;
      end else if (wr_valid) begin
         case (csr_idx_type'(wr_index))
            CSR_PROP_GAIN:      cfg_ff.prop_gain             <= wr_data[GAIN_W-1:0];
            CSR_INTEGRAL_GAIN:  cfg_ff.integral_gain         <= wr_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:     cfg_ff.deriv_gain_per_period <= wr_data[GAIN_W-1:0];
            CSR_PERIOD_FRAC:    cfg_ff.period_fraction       <= wr_data[GAIN_W-1:0];
            CSR_BASELINE_DUTY:  cfg_ff.baseline_duty         <= wr_data[DUTY_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_ff.integral_limit        <= wr_data[LIMIT_W-1:0];
            CSR_DUTY_MIN:       cfg_ff.duty_min              <= wr_data[DUTY_W-1:0];
            CSR_DUTY_MAX:       cfg_ff.duty_max              <= wr_data[DUTY_W-1:0];
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== src/pidad_ctrl.sv =====
// Controller: sequences the shared multiplier and the accumulator for each word
`timescale 1ns / 1ps
`default_nettype none
module pidad_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      pidad_pkg::dp_cmd_type cmd
);
   import pidad_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_IP,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_I,
      ST_SUM_I,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd               = '0;
      cmd.mul_sel       = MUL_ERR_PERIOD;
      cmd.load          = (state_ff == ST_IDLE) && req_valid;
      case (state_ff)
         ST_MUL_IP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR_PERIOD;
         end
         ST_MUL_P: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_ERR_PROP;
            cmd.integ_upd = 1'b1;
         end
         ST_MUL_D: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_DIFF_DERIV;
            cmd.acc_init = 1'b1;
         end
         ST_MUL_I: begin
            cmd.mul_en        = 1'b1;
            cmd.mul_sel       = MUL_INTEG_IGAIN;
            cmd.acc_add_shift = 1'b1;
         end
         ST_SUM_I:  cmd.acc_add_plain = 1'b1;
         ST_FINISH: cmd.out_load      = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE:   if (req_valid) state_ff <= ST_MUL_IP;
            ST_MUL_IP: state_ff <= ST_MUL_P;
            ST_MUL_P:  state_ff <= ST_MUL_D;
            ST_MUL_D:  state_ff <= ST_MUL_I;
            ST_MUL_I:  state_ff <= ST_SUM_I;
            ST_SUM_I:  state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== src/pidad_dpath.sv =====
// Datapath: error, shared multiplier, clamped integral, accumulator and duty saturation
`timescale 1ns / 1ps
`default_nettype none
module pidad_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pidad_pkg::dp_cmd_type               cmd,
   input  wire pidad_pkg::cfg_type                  cfg,
   input  wire logic signed [pidad_pkg::DATA_W-1:0] setpoint,
   input  wire logic signed [pidad_pkg::DATA_W-1:0] measured_altitude,
   output      logic [pidad_pkg::DUTY_W-1:0]        duty,
   output      logic                                integral_clamped,
   output      logic                                output_clamped
);
   import pidad_pkg::*;

   logic signed [ERR_W-1:0]   err_in;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [ERR_W-1:0]   prev_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;
   logic                      iclamp_ff;
   logic                      iclamp_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic [GAIN_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [IACC_W-1:0]  iacc;
   logic signed [IACC_W-1:0]  limit_pos;
   logic signed [IACC_W-1:0]  limit_neg;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   base_term;
   logic signed [ACC_W-1:0]   neg_bound;
   logic [WHOLE_W-1:0]        whole;
   logic [WHOLE_W-1:0]        lim_d;
   logic [WHOLE_W-1:0]        min_w;
   logic [WHOLE_W-1:0]        max_w;
   logic                      whole_neg;
   logic [DUTY_W-1:0]         duty_ff;
   logic [DUTY_W-1:0]         duty_in;
   logic                      oclamp_in;
   logic                      iclamp_out_ff;
   logic                      oclamp_ff;

   assign err_in = ERR_W'(setpoint) - ERR_W'(measured_altitude);

   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_PERIOD: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = cfg.period_fraction;
         end
         MUL_ERR_PROP: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = cfg.prop_gain;
         end
         MUL_DIFF_DERIV: begin
            mul_a = MUL_A_W'(diff_ff);
            mul_b = cfg.deriv_gain_per_period;
         end
         MUL_INTEG_IGAIN: begin
            mul_a = MUL_A_W'(integ_ff);
            mul_b = cfg.integral_gain;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
   end

   always_comb begin
      iacc      = IACC_W'(integ_ff) + IACC_W'(prod_ff);
      limit_pos = IACC_W'({cfg.integral_limit, {PERIOD_FRAC_BITS{1'b0}}});
      limit_neg = -limit_pos;
      integ_in  = INTEG_W'(iacc);
      iclamp_in = 1'b0;
      if (iacc > limit_pos) begin
         integ_in  = INTEG_W'(limit_pos);
         iclamp_in = 1'b1;
      end else if (iacc < limit_neg) begin
         integ_in  = INTEG_W'(limit_neg);
         iclamp_in = 1'b1;
      end
   end

   always_comb begin
      prod_ext  = ACC_W'(prod_ff);
      base_term = ACC_W'({cfg.baseline_duty, {SCALE_SH{1'b0}}});
      acc_in    = acc_ff;
      if (cmd.acc_init) begin
         acc_in = (prod_ext <<< PERIOD_FRAC_BITS) + base_term;
      end else if (cmd.acc_add_shift) begin
         acc_in = acc_ff + (prod_ext <<< PERIOD_FRAC_BITS);
      end else if (cmd.acc_add_plain) begin
         acc_in = acc_ff + prod_ext;
      end
   end

   always_comb begin
      neg_bound                   = '0;
      neg_bound[ACC_W-1:SCALE_SH] = '1;
      whole_neg = (acc_ff <= neg_bound);
      whole     = acc_ff[ACC_W-1] ? '0 : acc_ff[ACC_W-1:SCALE_SH];
      min_w     = WHOLE_W'(cfg.duty_min);
      max_w     = WHOLE_W'(cfg.duty_max);
      lim_d     = (whole <= min_w) ? min_w : whole;
      if (lim_d >= max_w) begin
         lim_d = max_w;
      end
      if (whole_neg) begin
         duty_in   = cfg.duty_min;
         oclamp_in = 1'b1;
      end else begin
         duty_in   = lim_d[DUTY_W-1:0];
         oclamp_in = (lim_d != whole);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
      end else begin
         if (cmd.load) begin
            prev_ff <= err_in;
         end
         if (cmd.integ_upd) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff  <= err_in;
         diff_ff <= DIFF_W'(err_in) - DIFF_W'(prev_ff);
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.integ_upd) begin
         iclamp_ff <= iclamp_in;
      end
      acc_ff <= acc_in;
      if (cmd.out_load) begin
         duty_ff       <= duty_in;
         iclamp_out_ff <= iclamp_ff;
         oclamp_ff     <= oclamp_in;
      end
   end

   assign duty             = duty_ff;
   assign integral_clamped = iclamp_out_ff;
   assign output_clamped   = oclamp_ff;
endmodule
`default_nettype wire

// ===== src/pid_altitude_duty_top.sv =====
// Top level: PID altitude controller with integral clamp, driving a duty output
//
//   channel   dir   handshake              word
//   req_ch    in    valid / ready          setpoint, measured_altitude
//   rsp_ch    out   valid / ready          duty, integral_clamped, output_clamped
//   csr_ch    in    valid / ready (ready)  index, data
//
// Each word steps through accept, four passes through the one shared multiplier,
// a final accumulate, and the saturation into the output register.
// A new word is taken once the previous result sits in the output register.
// A stalled response holds the sequencer in its last step until the register frees.
// Synchronous reset restores the register defaults and clears integral and last error.
`timescale 1ns / 1ps
`default_nettype none
module pid_altitude_duty_top (
   input wire logic clock,
   input wire logic reset,
   pidad_req_if.sink   req_ch,
   pidad_rsp_if.source rsp_ch,
   pidad_csr_if.sink   csr_ch
);
   import pidad_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;

   pidad_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_ready (csr_ch.ready),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   pidad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   pidad_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .setpoint          (req_ch.setpoint),
      .measured_altitude (req_ch.measured_altitude),
      .duty              (rsp_ch.duty),
      .integral_clamped  (rsp_ch.integral_clamped),
      .output_clamped    (rsp_ch.output_clamped)
   );
endmodule
`default_nettype wire

// ===== tb/pid_altitude_duty_top_tb.sv =====
// Testbench: PID duty controller driven through its word channels, checked against a predictor
`timescale 1ns / 1ps
module pid_altitude_duty_top_tb;
   import pidad_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE       = 10;
   localparam int RANDOM_WORDS = 100;
   localparam int RANDOM_SETS  = 8;

   class duty_tracker;
      typedef struct {
         logic [DUTY_W-1:0] duty;
         logic              iclamp;
         logic              oclamp;
      } duty_word_type;

      cfg_type       cfg;
      longint        integral;
      longint        last_err;
      duty_word_type pending_duty[$];
      int            mismatches;
      int            words_seen;
      int            iclamp_hits;
      int            oclamp_hits;

      function new();
         cfg.prop_gain             = RST_PROP_GAIN;
         cfg.integral_gain         = RST_INTEGRAL_GAIN;
         cfg.deriv_gain_per_period = RST_DERIV_GAIN;
         cfg.period_fraction       = RST_PERIOD_FRAC;
         cfg.baseline_duty         = RST_BASELINE_DUTY;
         cfg.integral_limit        = RST_INTEGRAL_LIMIT;
         cfg.duty_min              = RST_DUTY_MIN;
         cfg.duty_max              = RST_DUTY_MAX;
         integral    = 0;
         last_err    = 0;
         mismatches  = 0;
         words_seen  = 0;
         iclamp_hits = 0;
         oclamp_hits = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_PROP_GAIN:      cfg.prop_gain             = v;
            CSR_INTEGRAL_GAIN:  cfg.integral_gain         = v;
            CSR_DERIV_GAIN:     cfg.deriv_gain_per_period = v;
            CSR_PERIOD_FRAC:    cfg.period_fraction       = v;
            CSR_BASELINE_DUTY:  cfg.baseline_duty         = v[DUTY_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg.integral_limit        = v[LIMIT_W-1:0];
            CSR_DUTY_MIN:       cfg.duty_min              = v[DUTY_W-1:0];
            CSR_DUTY_MAX:       cfg.duty_max              = v[DUTY_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_sample(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] ma);
         longint        err, bound, acc, kp, ki, kd, per, base, lo, hi;
         longint        total, scale, whole, dv;
         duty_word_type w;
         kp    = cfg.prop_gain;
         ki    = cfg.integral_gain;
         kd    = cfg.deriv_gain_per_period;
         per   = cfg.period_fraction;
         base  = cfg.baseline_duty;
         lo    = cfg.duty_min;
         hi    = cfg.duty_max;
         err   = longint'(sp) - longint'(ma);
         bound = longint'(cfg.integral_limit) <<< PERIOD_FRAC_BITS;
         acc   = integral + err * per;
         w.iclamp = 1'b0;
         w.oclamp = 1'b0;
         if (acc > bound) begin
            acc      = bound;
            w.iclamp = 1'b1;
         end
         if (acc < -bound) begin
            acc      = -bound;
            w.iclamp = 1'b1;
         end
         scale = longint'(1) <<< (GAIN_FRAC_BITS + PERIOD_FRAC_BITS);
         total = ((err * kp + (err - last_err) * kd) <<< PERIOD_FRAC_BITS)
               + acc * ki + base * scale;
         whole = total / scale;
         if (whole < 0) begin
            dv       = lo;
            w.oclamp = 1'b1;
         end else begin
            dv = whole;
            if (dv <= lo) dv = lo;
            if (dv >= hi) dv = hi;
            w.oclamp = (dv != whole);
         end
         w.duty   = dv[DUTY_W-1:0];
         integral = acc;
         last_err = err;
         words_seen++;
         if (w.iclamp) iclamp_hits++;
         if (w.oclamp) oclamp_hits++;
         pending_duty.push_back(w);
      endfunction

      function void match_duty(logic [DUTY_W-1:0] duty, logic iclamp, logic oclamp);
         duty_word_type w;
         if (pending_duty.size() == 0) begin
            $error("unexpected result word: duty %0d", duty);
            mismatches++;
         end else begin
            w = pending_duty.pop_front();
            if (duty !== w.duty) begin
               $error("duty: expected %0d, got %0d", w.duty, duty);
               mismatches++;
            end
            if (iclamp !== w.iclamp) begin
               $error("integral_clamped: expected %0b, got %0b", w.iclamp, iclamp);
               mismatches++;
            end
            if (oclamp !== w.oclamp) begin
               $error("output_clamped: expected %0b, got %0b", w.oclamp, oclamp);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_cycles;
   int   rx_mode;
   int   rx_left;
   int   settings_used;
   logic signed [DATA_W-1:0] drift_alt;

   duty_tracker tracker = new();

   pidad_req_if req_ch();
   pidad_rsp_if rsp_ch();
   pidad_csr_if csr_ch();

   pid_altitude_duty_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_ch.valid             = 1'b0;
      req_ch.setpoint          = '0;
      req_ch.measured_altitude = '0;
      csr_ch.valid             = 1'b0;
      csr_ch.index             = '0;
      csr_ch.data              = '0;
      rsp_ch.ready             = 1'b0;
      rx_mode                  = 0;
      rx_left                  = 0;
   end

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_left = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_mode)
         0:       rsp_ch.ready = 1'b1;
         1:       rsp_ch.ready = 1'($urandom_range(0, 1));
         default: rsp_ch.ready = ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            tracker.set_reg(csr_idx_type'(csr_ch.index), csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            tracker.take_sample(req_ch.setpoint, req_ch.measured_altitude);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.match_duty(rsp_ch.duty, rsp_ch.integral_clamped, rsp_ch.output_clamped);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[pid_altitude_duty_top] ERROR");
      $finish;
   end

   task automatic send_word(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] ma);
      @(negedge clock);
      req_ch.valid             = 1'b1;
      req_ch.setpoint          = sp;
      req_ch.measured_altitude = ma;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic hold_off(int n);
      @(negedge clock);
      req_ch.valid = 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_words();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (tracker.pending_duty.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic put_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = v;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic load_settings(cfg_type c);
      put_reg(CSR_PROP_GAIN,      c.prop_gain);
      put_reg(CSR_INTEGRAL_GAIN,  c.integral_gain);
      put_reg(CSR_DERIV_GAIN,     c.deriv_gain_per_period);
      put_reg(CSR_PERIOD_FRAC,    c.period_fraction);
      put_reg(CSR_BASELINE_DUTY,  CSR_DATA_W'(c.baseline_duty));
      put_reg(CSR_INTEGRAL_LIMIT, CSR_DATA_W'(c.integral_limit));
      put_reg(CSR_DUTY_MIN,       CSR_DATA_W'(c.duty_min));
      put_reg(CSR_DUTY_MAX,       CSR_DATA_W'(c.duty_max));
      @(negedge clock);
      csr_ch.valid = 1'b0;
      settings_used++;
   endtask

   function automatic int unsigned pick(int unsigned lo, int unsigned hi, int unsigned usual);
      case ($urandom_range(0, 5))
         0:       return lo;
         1:       return hi;
         2:       return $urandom_range(lo, hi);
         default: return $urandom_range(lo, usual);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.prop_gain             = GAIN_W'(pick(0, 65535, 1024));
      c.integral_gain         = GAIN_W'(pick(0, 65535, 512));
      c.deriv_gain_per_period = GAIN_W'(pick(0, 65535, 2048));
      c.period_fraction       = GAIN_W'(pick(1, 65535, 4096));
      c.baseline_duty         = DUTY_W'(pick(0, 100, 100));
      c.integral_limit        = LIMIT_W'(pick(0, 32767, 400));
      c.duty_min              = DUTY_W'(pick(0, 100, 30));
      c.duty_max              = DUTY_W'(pick(0, 100, 100));
      return c;
   endfunction

   function automatic logic signed [DATA_W-1:0] edge_value();
      case ($urandom_range(0, 3))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return 16'shFFFF;
      endcase
   endfunction

   task automatic run_random(int n);
      int sent;
      int burst;
      int gap;
      int offset;
      logic signed [DATA_W-1:0] sp;
      logic signed [DATA_W-1:0] ma;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < n; i++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  offset    = $urandom_range(0, 64);
                  drift_alt = drift_alt + DATA_W'(offset - 32);
                  offset    = $urandom_range(0, 400);
                  ma        = drift_alt;
                  sp        = drift_alt + DATA_W'(offset - 200);
               end
               4, 5, 6: begin
                  sp = DATA_W'($urandom);
                  ma = DATA_W'($urandom);
               end
               7: begin
                  sp = edge_value();
                  ma = edge_value();
               end
               default: begin
                  offset = $urandom_range(0, 2000);
                  sp     = DATA_W'(offset - 1000);
                  offset = $urandom_range(0, 2000);
                  ma     = DATA_W'(offset - 1000);
               end
            endcase
            send_word(sp, ma);
            sent++;
         end
         case ($urandom_range(0, 7))
            0, 1, 2: gap = 0;
            3:       gap = $urandom_range(20, 40);
            default: gap = $urandom_range(1, 12);
         endcase
         if (gap > 0) hold_off(gap);
      end
   endtask

   initial begin
      cfg_type c;
      settings_used = 1;
      drift_alt     = DATA_W'($urandom);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(16'sd0, 16'sd0);
      send_word(16'sh7FFF, 16'sh8000);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sd50, 16'sd0);
      send_word(-16'sd50, 16'sd0);
      send_word(16'sh7FFF, 16'sh7FFF);
      drain_words();

      // land the integral exactly on its bound, then push past it
      c.prop_gain             = 16'd0;
      c.integral_gain         = 16'd256;
      c.deriv_gain_per_period = 16'd0;
      c.period_fraction       = 16'd16384;
      c.baseline_duty         = 7'd0;
      c.integral_limit        = 15'd100;
      c.duty_min              = 7'd0;
      c.duty_max              = 7'd100;
      load_settings(c);
      send_word(16'sd400, 16'sd0);
      send_word(16'sd0, 16'sd0);
      send_word(16'sd1, 16'sd0);
      send_word(-16'sd400, 16'sd0);
      send_word(16'sh8000, 16'sh7FFF);
      drain_words();

      // inverted window, no integration, full gains
      c.prop_gain             = 16'hFFFF;
      c.integral_gain         = 16'hFFFF;
      c.deriv_gain_per_period = 16'hFFFF;
      c.period_fraction       = 16'd0;
      c.baseline_duty         = 7'd100;
      c.integral_limit        = 15'h7FFF;
      c.duty_min              = 7'd60;
      c.duty_max              = 7'd40;
      load_settings(c);
      send_word(16'sd0, 16'sd0);
      send_word(16'sh7FFF, 16'sh8000);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sd0, 16'sd0);
      send_word(16'sd1, 16'sd1);
      drain_words();

      // baseline alone, sitting exactly on a closed window
      c.prop_gain             = 16'd0;
      c.integral_gain         = 16'd0;
      c.deriv_gain_per_period = 16'd0;
      c.period_fraction       = 16'hFFFF;
      c.baseline_duty         = 7'd20;
      c.integral_limit        = 15'd0;
      c.duty_min              = 7'd20;
      c.duty_max              = 7'd20;
      load_settings(c);
      send_word(16'sd10, 16'sd0);
      send_word(-16'sd10, 16'sd0);
      send_word(16'sd0, 16'sd0);
      drain_words();

      for (int p = 0; p < RANDOM_SETS; p++) begin
         load_settings(random_settings());
         run_random(RANDOM_WORDS);
         drain_words();
      end

      $display("covered %0d words over %0d register settings", tracker.words_seen,
               settings_used);
      $display("integral clamped on %0d words, duty clamped on %0d", tracker.iclamp_hits,
               tracker.oclamp_hits);
      if (tracker.mismatches == 0 && tracker.pending_duty.size() == 0)
         $display("[pid_altitude_duty_top] OK");
      else
         $display("[pid_altitude_duty_top] ERROR");
      $finish;
   end

endmodule
